// ===== rtl/qsl_pkg.sv =====
package qsl_pkg;
    localparam int LoopDepth  = 65536;
    localparam int AddrBits   = $clog2(LoopDepth);
    localparam int PosBits    = AddrBits + 1;
    localparam int SampleBits = 16;
    localparam int GainBits   = 16;
    localparam int SmoothBits = 32;
    localparam int CoeffBits  = 16;
    localparam int CfgIdxBits = 1;
    localparam int CfgDataBits = 16;

    localparam logic [CfgIdxBits-1:0] CfgQuantize = 1'd0;
    localparam logic [CfgIdxBits-1:0] CfgCoeff    = 1'd1;
    localparam logic [CoeffBits-1:0]  CoeffReset  = 16'd655;

    typedef enum logic [1:0] {
        MODE_STOP    = 2'd0,
        MODE_RECORD  = 2'd1,
        MODE_PLAY    = 2'd2,
        MODE_OVERDUB = 2'd3
    } t_mode;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture input word, start smoothing
        logic rd;       // issue memory read
        logic mix;      // compute outputs and write back
    } t_cmd;

    function automatic logic signed [SampleBits-1:0] sat(input logic signed [SampleBits+1:0] v);
        logic signed [SampleBits+1:0] hi;
        logic signed [SampleBits+1:0] lo;
        hi = (SampleBits+2)'((1 << (SampleBits-1)) - 1);
        lo = -hi - (SampleBits+2)'(1);
        if (v > hi) return hi[SampleBits-1:0];
        else if (v < lo) return lo[SampleBits-1:0];
        return v[SampleBits-1:0];
    endfunction
endpackage

// ===== rtl/qsl_ctrl.sv =====
module qsl_ctrl import qsl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);
    typedef enum logic [1:0] {S_IDLE, S_READ, S_MIX, S_OUT} t_state;
    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_in_valid) r_state <= S_READ;
                S_READ: r_state <= S_MIX;
                S_MIX:  r_state <= S_OUT;
                S_OUT:  if (i_out_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.rd    = (r_state == S_READ);
    assign o_cmd.mix   = (r_state == S_MIX);
endmodule

// ===== rtl/qsl_dp.sv =====
module qsl_dp import qsl_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    input  logic                         i_quantize,
    input  logic [CoeffBits-1:0]         i_coeff,
    input  logic signed [SampleBits-1:0] i_in_left,
    input  logic signed [SampleBits-1:0] i_in_right,
    input  logic                         i_beat_pulse,
    input  logic [1:0]                   i_requested_mode,
    input  logic [GainBits-1:0]          i_level_target,
    input  logic [GainBits-1:0]          i_feedback_target,
    output logic signed [SampleBits-1:0] o_out_left,
    output logic signed [SampleBits-1:0] o_out_right,
    output logic [1:0]                   o_mode_now,
    output logic                         o_change_waiting,
    output logic [PosBits-1:0]           o_loop_length_now
);
    logic signed [SampleBits-1:0] mem_l [LoopDepth];
    logic signed [SampleBits-1:0] mem_r [LoopDepth];

    logic signed [SampleBits-1:0] r_xl, r_xr, r_ll, r_lr;
    logic [GainBits-1:0] r_tl, r_tf;
    logic [PosBits-1:0]  r_pos, r_len, r_addr;
    t_mode r_mode, r_pmode;
    logic  r_pend;
    logic [SmoothBits-1:0] r_sl, r_sf;
    logic signed [SmoothBits+CoeffBits:0] r_pl, r_pf;   // registered smoothing products

    // mode resolution for the captured word (request then beat)
    t_mode m1, m2;
    logic  p1, p2, rec;
    logic [1:0] pm1;
    always_comb begin
        m1 = r_mode; p1 = r_pend; pm1 = r_pmode; rec = 1'b0;
        if (i_requested_mode != r_mode && !r_pend) begin
            if (i_quantize) begin
                p1 = 1'b1; pm1 = i_requested_mode;
            end else begin
                m1 = t_mode'(i_requested_mode);
                rec = (m1 == MODE_RECORD);
            end
        end
        m2 = m1; p2 = p1;
        if (p1 && i_beat_pulse) begin
            p2 = 1'b0; m2 = t_mode'(pm1);
            rec = rec | (m2 == MODE_RECORD);
        end
    end

    // smoothing diff times coefficient: 33-bit by 17-bit, floor >> 16
    logic signed [SmoothBits:0] dl, df;
    assign dl = $signed({1'b0, r_tl, 16'd0}) - $signed({1'b0, r_sl});
    assign df = $signed({1'b0, r_tf, 16'd0}) - $signed({1'b0, r_sf});

    // smoothed gains for this word, used by the mix
    logic [SmoothBits-1:0] n_sl, n_sf;
    assign n_sl = r_sl + SmoothBits'(r_pl >>> 16);
    assign n_sf = r_sf + SmoothBits'(r_pf >>> 16);

    logic [PosBits-1:0] p_rd;
    assign p_rd = (r_pos >= r_len || r_pos >= PosBits'(LoopDepth)) ? '0 : r_pos;

    logic [GainBits-1:0] lvl, fb;
    logic signed [SampleBits+GainBits+1:0] gl, gr, fl, fr;
    always_comb begin
        lvl = n_sl[SmoothBits-1 -: GainBits];
        fb  = n_sf[SmoothBits-1 -: GainBits];
        gl = (r_ll * $signed({1'b0, lvl})) >>> 15;
        gr = (r_lr * $signed({1'b0, lvl})) >>> 15;
        fl = (r_ll * $signed({1'b0, fb})) >>> 15;
        fr = (r_lr * $signed({1'b0, fb})) >>> 15;
    end
    logic signed [SampleBits+1:0] sl_o, sr_o, sl_w, sr_w;
    assign sl_o = (SampleBits+2)'(r_xl) + (SampleBits+2)'(gl);
    assign sr_o = (SampleBits+2)'(r_xr) + (SampleBits+2)'(gr);
    assign sl_w = (SampleBits+2)'(r_xl) + (SampleBits+2)'(fl);
    assign sr_w = (SampleBits+2)'(r_xr) + (SampleBits+2)'(fr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_STOP; r_pmode <= MODE_STOP; r_pend <= 1'b0;
            r_pos <= '0; r_len <= '0; r_sl <= '0; r_sf <= '0;
        end else if (i_cmd.load) begin
            r_xl <= i_in_left; r_xr <= i_in_right;
            r_tl <= i_level_target; r_tf <= i_feedback_target;
            r_mode <= m2; r_pend <= p2; r_pmode <= t_mode'(pm1);
            if (rec) begin
                r_pos <= '0; r_len <= '0;
            end
        end else if (i_cmd.rd) begin
            r_pl <= dl * $signed({1'b0, i_coeff});
            r_pf <= df * $signed({1'b0, i_coeff});
            r_addr <= p_rd;
            r_ll <= mem_l[p_rd[AddrBits-1:0]];
            r_lr <= mem_r[p_rd[AddrBits-1:0]];
        end else if (i_cmd.mix) begin
            r_sl <= n_sl;
            r_sf <= n_sf;
            o_out_left <= r_xl; o_out_right <= r_xr;
            unique case (r_mode)
                MODE_RECORD: begin
                    if (r_pos < PosBits'(LoopDepth)) begin
                        mem_l[r_pos[AddrBits-1:0]] <= r_xl;
                        mem_r[r_pos[AddrBits-1:0]] <= r_xr;
                        r_pos <= r_pos + 1'b1;
                        r_len <= r_pos + 1'b1;
                    end
                end
                MODE_PLAY, MODE_OVERDUB: begin
                    if (r_len != '0) begin
                        o_out_left <= sat(sl_o); o_out_right <= sat(sr_o);
                        if (r_mode == MODE_OVERDUB) begin
                            mem_l[r_addr[AddrBits-1:0]] <= sat(sl_w);
                            mem_r[r_addr[AddrBits-1:0]] <= sat(sr_w);
                        end
                        r_pos <= (r_addr + 1'b1 >= r_len) ? '0 : r_addr + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_mode_now        = r_mode;
    assign o_change_waiting  = r_pend;
    assign o_loop_length_now = r_len;
endmodule

// ===== rtl/quantized_stereo_looper.sv =====
// Quantized stereo looper with overdub.
// Input channel: one stereo frame per word (samples, beat pulse, requested
// mode, level and feedback targets), valid/ready handshake.
// Output channel: one word per input word (mixed samples, mode in force,
// pending-change flag, loop length), valid/ready handshake.
// Config port: i_cfg_we/i_cfg_idx/i_cfg_data; 0 quantize enable,
// 1 smoothing coefficient (Q0.16). Write only while idle.
// Flow: a word passes through the controller states capture, loop store
// read and mix/write-back, then the result is held until taken. One word is
// in flight at a time.
// Reset (sync, active low): mode stop, position, length, smoothed gains and
// pending change cleared; loop store contents are undefined until recorded.
// A stalled receiver holds the result and blocks new input words.
module quantized_stereo_looper import qsl_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CfgIdxBits-1:0]        i_cfg_idx,
    input  logic [CfgDataBits-1:0]       i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [SampleBits-1:0] i_in_left,
    input  logic signed [SampleBits-1:0] i_in_right,
    input  logic                         i_beat_pulse,
    input  logic [1:0]                   i_requested_mode,
    input  logic [GainBits-1:0]          i_level_target,
    input  logic [GainBits-1:0]          i_feedback_target,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [SampleBits-1:0] o_out_left,
    output logic signed [SampleBits-1:0] o_out_right,
    output logic [1:0]                   o_mode_now,
    output logic                         o_change_waiting,
    output logic [PosBits-1:0]           o_loop_length_now
);
    logic                 r_quantize;
    logic [CoeffBits-1:0] r_coeff;
    t_cmd                 cmd;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantize <= 1'b0;
            r_coeff    <= CoeffReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CfgQuantize: r_quantize <= i_cfg_data[0];
                CfgCoeff:    r_coeff    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    qsl_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
        .o_cmd(cmd)
    );

    qsl_dp u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_quantize(r_quantize), .i_coeff(r_coeff),
        .i_in_left, .i_in_right, .i_beat_pulse, .i_requested_mode,
        .i_level_target, .i_feedback_target,
        .o_out_left, .o_out_right, .o_mode_now, .o_change_waiting, .o_loop_length_now
    );

`ifndef SYNTHESIS
    // no new word while a result is held
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready while result held");
    // accepted word yields a result after the read and mix states
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> ##3 o_out_valid) else $error("latency");
    // length never exceeds depth
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_loop_length_now <= PosBits'(LoopDepth)) else $error("length");
`endif
endmodule
